>>> rtl/core/rgbds_pkg.sv
// Shared types, constants and pixel math for the RGB565 downscaler.
`timescale 1ns / 1ps
`default_nettype none

package rgbds_pkg;

	localparam int DIM_W   = 12;   // register and clamped dimension width
	localparam int POS_W   = 11;   // position and coordinate width
	localparam int NUMER_W = 22;   // running numerator width
	localparam int PIX_W   = 16;
	localparam int MONO_W  = 8;
	localparam int LUMA_W  = 18;   // 299*R + 587*G + 114*B fits below 2^18

	localparam logic [DIM_W-1:0] MAX_DIM = 12'd2048;

	localparam logic [DIM_W-1:0] RST_SRC_W = 12'd320;
	localparam logic [DIM_W-1:0] RST_SRC_H = 12'd240;
	localparam logic [DIM_W-1:0] RST_TGT_W = 12'd128;
	localparam logic [DIM_W-1:0] RST_TGT_H = 12'd64;

	localparam logic [LUMA_W-1:0] LUMA_THRESH = 18'd128000;
	localparam logic [MONO_W-1:0] MONO_WHITE  = 8'hFF;
	localparam logic [MONO_W-1:0] MONO_BLACK  = 8'h00;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_TGT_W = 2'd2,
		REG_TGT_H = 2'd3
	} cfg_reg_t;

	// Effective dimensions, already clamped; target never exceeds source.
	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] tw;
		logic [DIM_W-1:0] th;
	} dims_t;

	// One selected source pixel on its way to the luma stage.
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             last;
	} sel_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = 12'd1;
		else if (v > MAX_DIM)
			r = MAX_DIM;
		return r;
	endfunction

	// c*255/31 = 8c + floor(7c/31); the floor steps at fixed thresholds.
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [2:0] f;
		f = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
		  + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
		return {c, 3'b000} + {5'b0, f};
	endfunction

	// c*255/63 = 4c + floor(c/21).
	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [1:0] f;
		f = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
		return {c, 2'b00} + {6'b0, f};
	endfunction

	function automatic logic [MONO_W-1:0] mono_of(input logic [PIX_W-1:0] px);
		logic [7:0]        r;
		logic [7:0]        g;
		logic [7:0]        b;
		logic [LUMA_W-1:0] sum;
		r   = expand5(px[15:11]);
		g   = expand6(px[10:5]);
		b   = expand5(px[4:0]);
		sum = {10'b0, r} * 18'd299 + {10'b0, g} * 18'd587 + {10'b0, b} * 18'd114;
		return (sum >= LUMA_THRESH) ? MONO_WHITE : MONO_BLACK;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/rgbds_cfg.sv
// Dimension registers with clamping applied on write.
`timescale 1ns / 1ps
`default_nettype none

module rgbds_cfg (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [1:0]              cfg_index,
	input  wire  [rgbds_pkg::DIM_W-1:0] cfg_data,
	output rgbds_pkg::dims_t        dims
);
	import rgbds_pkg::*;

	logic [DIM_W-1:0] sw_q;
	logic [DIM_W-1:0] sh_q;
	logic [DIM_W-1:0] tw_q;
	logic [DIM_W-1:0] th_q;
	logic [DIM_W-1:0] wdata;

	assign cfg_ready = 1'b1;
	assign wdata     = clamp_dim(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= RST_SRC_W;
			sh_q <= RST_SRC_H;
			tw_q <= RST_TGT_W;
			th_q <= RST_TGT_H;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_W: sw_q <= wdata;
				REG_SRC_H: sh_q <= wdata;
				REG_TGT_W: tw_q <= wdata;
				REG_TGT_H: th_q <= wdata;
				default:   sw_q <= sw_q;
			endcase
		end
	end

	// Downscale only: target clamps to source.
	always_comb begin
		dims.sw = sw_q;
		dims.sh = sh_q;
		dims.tw = (tw_q > sw_q) ? sw_q : tw_q;
		dims.th = (th_q > sh_q) ? sh_q : th_q;
	end

endmodule

`default_nettype wire

>>> rtl/core/rgbds_select.sv
// Raster counters and nearest-neighbor selection, with the stage 1 register.
`timescale 1ns / 1ps
`default_nettype none

module rgbds_select (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  rgbds_pkg::dims_t  dims,
	input  wire                     pixel_valid,
	output logic                    pixel_stall,
	input  wire  [rgbds_pkg::PIX_W-1:0] pixel_rgb565,
	input  wire                     frame_start,
	output logic                    valid_s1,
	output rgbds_pkg::sel_t         sel_s1,
	input  wire                     take_s1
);
	import rgbds_pkg::*;

	logic [POS_W-1:0]   scol_q, srow_q, ocol_q, orow_q;
	logic [NUMER_W-1:0] ctn_q, csn_q, rtn_q, rsn_q;

	logic [POS_W-1:0]   e_scol, e_srow, e_ocol, e_orow;
	logic [NUMER_W-1:0] e_ctn, e_csn, e_rtn, e_rsn;
	logic [POS_W-1:0]   n_scol, n_srow, n_ocol, n_orow;
	logic [NUMER_W-1:0] n_ctn, n_csn, n_rtn, n_rsn;

	logic [NUMER_W-1:0] tw_n, th_n, sw_n, sh_n;
	logic [DIM_W-1:0]   ocol_inc, orow_inc, scol_inc, srow_inc;
	logic               row_sel, col_sel, hit, last, line_end, src_frame_end;
	logic               accept, s1_en;

	assign s1_en       = !valid_s1 || take_s1;
	assign pixel_stall = !s1_en;
	assign accept      = pixel_valid && !pixel_stall;

	assign tw_n = {{(NUMER_W-DIM_W){1'b0}}, dims.tw};
	assign th_n = {{(NUMER_W-DIM_W){1'b0}}, dims.th};
	assign sw_n = {{(NUMER_W-DIM_W){1'b0}}, dims.sw};
	assign sh_n = {{(NUMER_W-DIM_W){1'b0}}, dims.sh};

	always_comb begin
		// frame_start clears everything before the pixel is looked at
		e_scol = frame_start ? '0 : scol_q;
		e_srow = frame_start ? '0 : srow_q;
		e_ocol = frame_start ? '0 : ocol_q;
		e_orow = frame_start ? '0 : orow_q;
		e_ctn  = frame_start ? '0 : ctn_q;
		e_csn  = frame_start ? '0 : csn_q;
		e_rtn  = frame_start ? '0 : rtn_q;
		e_rsn  = frame_start ? '0 : rsn_q;

		row_sel = ({1'b0, e_orow} < dims.th)
		       && ({1'b0, e_rsn} < ({1'b0, e_rtn} + {1'b0, th_n}));
		col_sel = ({1'b0, e_ocol} < dims.tw)
		       && ({1'b0, e_csn} < ({1'b0, e_ctn} + {1'b0, tw_n}));
		hit = row_sel && col_sel;

		ocol_inc      = {1'b0, e_ocol} + 12'd1;
		orow_inc      = {1'b0, e_orow} + 12'd1;
		scol_inc      = {1'b0, e_scol} + 12'd1;
		srow_inc      = {1'b0, e_srow} + 12'd1;
		last          = (ocol_inc == dims.tw) && (orow_inc == dims.th);
		line_end      = scol_inc >= dims.sw;
		src_frame_end = srow_inc >= dims.sh;

		n_scol = e_scol;
		n_srow = e_srow;
		n_ocol = e_ocol;
		n_orow = e_orow;
		n_ctn  = e_ctn;
		n_csn  = e_csn;
		n_rtn  = e_rtn;
		n_rsn  = e_rsn;

		if (hit) begin
			n_ocol = ocol_inc[POS_W-1:0];
			if ({1'b0, n_ocol} < dims.tw)
				n_csn = e_csn + sw_n;
		end

		if (line_end) begin
			n_scol = '0;
			n_ctn  = '0;
			n_csn  = '0;
			n_ocol = '0;
			if (row_sel) begin
				n_orow = orow_inc[POS_W-1:0];
				if ({1'b0, n_orow} < dims.th)
					n_rsn = e_rsn + sh_n;
			end
			if (src_frame_end) begin
				// wrap: next pixel starts a new frame
				n_srow = '0;
				n_orow = '0;
				n_rtn  = '0;
				n_rsn  = '0;
			end else begin
				n_srow = srow_inc[POS_W-1:0];
				n_rtn  = e_rtn + th_n;
			end
		end else begin
			n_scol = scol_inc[POS_W-1:0];
			n_ctn  = e_ctn + tw_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scol_q   <= '0;
			srow_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			ctn_q    <= '0;
			csn_q    <= '0;
			rtn_q    <= '0;
			rsn_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				scol_q <= n_scol;
				srow_q <= n_srow;
				ocol_q <= n_ocol;
				orow_q <= n_orow;
				ctn_q  <= n_ctn;
				csn_q  <= n_csn;
				rtn_q  <= n_rtn;
				rsn_q  <= n_rsn;
			end
			if (s1_en)
				valid_s1 <= accept && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && accept && hit) begin
			sel_s1.pixel <= pixel_rgb565;
			sel_s1.x     <= e_ocol;
			sel_s1.y     <= e_orow;
			sel_s1.last  <= last;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rgbds_luma.sv
// Channel expansion, luma threshold and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rgbds_luma (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      valid_s1,
	input  wire  rgbds_pkg::sel_t    sel_s1,
	output logic                     take_s1,
	output logic                     result_valid,
	input  wire                      result_stall,
	output logic [rgbds_pkg::MONO_W-1:0] mono_value,
	output logic [rgbds_pkg::POS_W-1:0]  target_x,
	output logic [rgbds_pkg::POS_W-1:0]  target_y,
	output logic                     frame_end
);
	import rgbds_pkg::*;

	logic              valid_s2;
	logic [MONO_W-1:0] mono_s2;
	logic [POS_W-1:0]  x_s2;
	logic [POS_W-1:0]  y_s2;
	logic              last_s2;

	// advance when the result register is empty or being drained
	assign take_s1 = !valid_s2 || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (take_s1)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			mono_s2 <= mono_of(sel_s1.pixel);
			x_s2    <= sel_s1.x;
			y_s2    <= sel_s1.y;
			last_s2 <= sel_s1.last;
		end
	end

	assign result_valid = valid_s2;
	assign mono_value   = mono_s2;
	assign target_x     = x_s2;
	assign target_y     = y_s2;
	assign frame_end    = last_s2;

endmodule

`default_nettype wire

>>> rtl/core/rgb565_downscale_to_mono.sv
// Top level: RGB565 nearest-neighbor downscaler with black/white luma threshold.
// A selected pixel passes through the stage 1 register and then the result register.
// One pixel per cycle while pixel_stall is low; the raster counters update once per accepted pixel.
// Pixels not picked by the scaler produce no result; pixel_stall rises only while both
// pipeline registers are full and result_stall is high.
// Reset: counters cleared, dimensions 320x240 to 128x64, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_downscale_to_mono (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [1:0]                   cfg_index,
	input  wire  [rgbds_pkg::DIM_W-1:0]  cfg_data,
	input  wire                          pixel_valid,
	output logic                         pixel_stall,
	input  wire  [rgbds_pkg::PIX_W-1:0]  pixel_rgb565,
	input  wire                          frame_start,
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic [rgbds_pkg::MONO_W-1:0] mono_value,
	output logic [rgbds_pkg::POS_W-1:0]  target_x,
	output logic [rgbds_pkg::POS_W-1:0]  target_y,
	output logic                         frame_end
);
	import rgbds_pkg::*;

	dims_t dims;
	sel_t  sel_s1;
	logic  valid_s1;
	logic  take_s1;

	rgbds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dims      (dims)
	);

	rgbds_select u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.dims         (dims),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_rgb565 (pixel_rgb565),
		.frame_start  (frame_start),
		.valid_s1     (valid_s1),
		.sel_s1       (sel_s1),
		.take_s1      (take_s1)
	);

	rgbds_luma u_luma (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.sel_s1       (sel_s1),
		.take_s1      (take_s1),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.mono_value   (mono_value),
		.target_x     (target_x),
		.target_y     (target_y),
		.frame_end    (frame_end)
	);

endmodule

`default_nettype wire

>>> rtl/core/rgbds_checker.sv
// Port-level checks for the downscaler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rgbds_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        pixel_valid,
	input wire        pixel_stall,
	input wire        result_valid,
	input wire        result_stall,
	input wire [7:0]  mono_value,
	input wire [10:0] target_x,
	input wire [10:0] target_y,
	input wire        frame_end
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid
		&& $stable({mono_value, target_x, target_y, frame_end}))
		else $error("result changed while stalled");

	// input backpressure only when the output is full and blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid && result_stall)
		else $error("pixel stalled without output backpressure");

	// every new result comes from an accepted pixel that went through the stage 1 register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pixel_valid && !pixel_stall, 2))
		else $error("result without a matching pixel transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (mono_value == 8'h00 || mono_value == 8'hFF))
		else $error("mono value neither black nor white");

endmodule

bind rgb565_downscale_to_mono rgbds_checker u_rgbds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_stall  (pixel_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.mono_value   (mono_value),
	.target_x     (target_x),
	.target_y     (target_y),
	.frame_end    (frame_end)
);

`default_nettype wire
